// ----- rtl/tsgd_pkg.sv -----
// ----------------------------------------------------------------------------
// tsgd_pkg: shared types and constants of the touch sweep gesture detector
// Event codes, register indexes, swipe box tables and the stage record.
// ----------------------------------------------------------------------------
package tsgd_pkg;

	localparam int IN_COORD_BITS = 12;
	localparam int TB_BITS       = 14;
	localparam int TABLE_SIZE    = 4;
	localparam int DYN_EN_LSB    = 4;
	localparam int TAP_EN_BIT    = 8;
	localparam int PRESS_BITS    = 3;
	localparam int PRESS_SUM_BITS = 4;

	typedef enum logic [2:0] {
		CMD_X          = 3'd0,
		CMD_Y          = 3'd1,
		CMD_SLOT       = 3'd2,
		CMD_LIFT       = 3'd3,
		CMD_SCREEN_ON  = 3'd4,
		CMD_SCREEN_OFF = 3'd5,
		CMD_TICK       = 3'd6
	} cmd_t;

	localparam logic [7:0] CFG_ENABLE_MASK   = 8'd0;
	localparam logic [7:0] CFG_BUTTON_LIMIT  = 8'd1;
	localparam logic [7:0] CFG_STATUS_BAR    = 8'd2;
	localparam logic [7:0] CFG_TAP_WINDOW    = 8'd3;

	typedef logic signed [TB_BITS-1:0] coord_t;

	localparam coord_t SX_LO [3][TABLE_SIZE] = '{
		'{14'sd700, 14'sd0,   14'sd700, 14'sd0},
		'{14'sd350, 14'sd350, 14'sd350, 14'sd350},
		'{14'sd0,   14'sd700, 14'sd0,   14'sd700}
	};
	localparam coord_t SX_HI [3][TABLE_SIZE] = '{
		'{14'sd1280, 14'sd300,  14'sd1280, 14'sd300},
		'{14'sd650,  14'sd650,  14'sd650,  14'sd650},
		'{14'sd300,  14'sd1280, 14'sd300,  14'sd1280}
	};
	localparam coord_t SY_LO [TABLE_SIZE] = '{14'sd1900, 14'sd1900, 14'sd1700, 14'sd1700};
	localparam coord_t SY_HI [TABLE_SIZE] = '{14'sd2400, 14'sd2400, 14'sd1920, 14'sd1920};

	localparam coord_t DX_LO1  = 14'sd800;
	localparam coord_t DX_HI1  = 14'sd1280;
	localparam coord_t DY_LO1  = 14'sd800;
	localparam coord_t DY_HI1  = 14'sd1600;
	localparam coord_t DX_OFF  = -14'sd300;
	localparam coord_t DX_SIZE = 14'sd200;
	localparam coord_t DY_OFF  = 14'sd100;
	localparam coord_t DY_SIZE = 14'sd200;

	typedef struct packed {
		logic [TABLE_SIZE-1:0] s1;
		logic [TABLE_SIZE-1:0] s2;
		logic                  d1;
		logic                  d2;
		coord_t                tx_lo;
		coord_t                tx_hi;
		coord_t                ty_lo;
		coord_t                ty_hi;
	} stage_t;

	typedef struct packed {
		logic tap;
		logic tick;
	} tap_ctrl_t;

	function automatic logic in_box(coord_t x, coord_t y, coord_t xl, coord_t xh,
			coord_t yl, coord_t yh);
		return (x < xh) && (x > xl) && (y < yh) && (y > yl);
	endfunction

	function automatic stage_t clear_stages(stage_t s);
		stage_t r;
		r    = s;
		r.s1 = '0;
		r.s2 = '0;
		r.d1 = 1'b0;
		r.d2 = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/tsgd_detect.sv -----
// ----------------------------------------------------------------------------
// tsgd_detect: swipe bank evaluation
// Tests a latched point against the static banks and then the dynamic banks,
// returning the updated stage record and what fired.
// ----------------------------------------------------------------------------
module tsgd_detect
	import tsgd_pkg::*;
#(
	parameter int STATIC_BANK_COUNT  = 4,
	parameter int DYNAMIC_BANK_COUNT = 1,
	parameter int LATCH_BITS         = 12
) (
	input  logic [LATCH_BITS-1:0]     x,
	input  logic [LATCH_BITS-1:0]     y,
	input  logic [8:0]                enable_mask,
	input  stage_t                    stage_in,
	output stage_t                    stage_out,
	output logic [PRESS_SUM_BITS-1:0] presses,
	output logic [TABLE_SIZE-1:0]     static_fired,
	output logic                      dynamic_fired
);

	coord_t cx;
	coord_t cy;
	stage_t st;
	logic [PRESS_SUM_BITS-1:0] pr;
	logic [TABLE_SIZE-1:0]     sf;
	logic                      df;

	assign cx = coord_t'({{(TB_BITS-LATCH_BITS){1'b0}}, x});
	assign cy = coord_t'({{(TB_BITS-LATCH_BITS){1'b0}}, y});

	always_comb begin
		st = stage_in;
		pr = '0;
		sf = '0;
		df = 1'b0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (i < STATIC_BANK_COUNT && enable_mask[i]) begin
				if (st.s1[i] || in_box(cx, cy, SX_LO[0][i], SX_HI[0][i], SY_LO[i], SY_HI[i])) begin
					st.s1[i] = 1'b1;
					if (st.s2[i] ||
							in_box(cx, cy, SX_LO[1][i], SX_HI[1][i], SY_LO[i], SY_HI[i])) begin
						st.s2[i] = 1'b1;
						if (in_box(cx, cy, SX_LO[2][i], SX_HI[2][i], SY_LO[i], SY_HI[i])) begin
							pr    = PRESS_SUM_BITS'(pr + 1'b1);
							sf[i] = 1'b1;
							st    = clear_stages(st);
						end
					end
				end
			end
		end
		for (int j = 0; j < TABLE_SIZE; j++) begin
			if (j < DYNAMIC_BANK_COUNT && enable_mask[DYN_EN_LSB + j]) begin
				if (st.d1 || in_box(cx, cy, DX_LO1, DX_HI1, DY_LO1, DY_HI1)) begin
					if (!st.d1) begin
						st.d1    = 1'b1;
						st.tx_lo = cx + DX_OFF;
						st.tx_hi = st.tx_lo + DX_SIZE;
						st.ty_lo = cy + DY_OFF;
						st.ty_hi = st.ty_lo + DY_SIZE;
					end
					if (st.d2 || in_box(cx, cy, st.tx_lo, st.tx_hi, st.ty_lo, st.ty_hi)) begin
						if (!st.d2) begin
							st.d2    = 1'b1;
							st.tx_lo = cx + DX_OFF;
							st.tx_hi = st.tx_lo + DX_SIZE;
							st.ty_lo = cy + DY_OFF;
							st.ty_hi = st.ty_lo + DY_SIZE;
						end
						if (in_box(cx, cy, st.tx_lo, st.tx_hi, st.ty_lo, st.ty_hi)) begin
							pr = PRESS_SUM_BITS'(pr + 1'b1);
							df = 1'b1;
							st = clear_stages(st);
						end
					end
				end
			end
		end
	end

	assign stage_out     = st;
	assign presses       = pr;
	assign static_fired  = sf;
	assign dynamic_fired = df;

endmodule

// ----- rtl/tsgd_tap.sv -----
// ----------------------------------------------------------------------------
// tsgd_tap: status bar double tap timer
// Arms on a first status bar lift, fires on a second one and disarms when
// the tick countdown runs out.
// ----------------------------------------------------------------------------
module tsgd_tap
	import tsgd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tap_ctrl_t   ctrl,
	input  logic [15:0] window,
	output logic        armed,
	output logic        fire
);

	logic        armed_q;
	logic [15:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			count_q <= '0;
		end else if (ctrl.tap) begin
			if (armed_q) begin
				armed_q <= 1'b0;
			end else begin
				armed_q <= 1'b1;
				count_q <= window;
			end
		end else if (ctrl.tick && armed_q) begin
			if (count_q <= 16'd1) begin
				count_q <= '0;
				armed_q <= 1'b0;
			end else begin
				count_q <= count_q - 16'd1;
			end
		end
	end

	assign armed = armed_q;
	assign fire  = ctrl.tap && armed_q;

endmodule

// ----- rtl/touch_sweep_gesture_detector_core.sv -----
// ----------------------------------------------------------------------------
// touch_sweep_gesture_detector_core: touch gesture to power key detector
// Latches touch points, tracks swipe banks and the status bar double tap.
// ----------------------------------------------------------------------------
// Touch events arrive on the s_ stream: s_tuser carries the event code and
// s_tdata the coordinate for X and Y events. Every accepted event yields
// exactly one result request on the m_ stream with the press count and the
// banks that fired, all zero when the event caused nothing.
// Each event is evaluated in the cycle it is accepted and the result sits in
// the output register on the next cycle; one event is taken every cycle
// while the receiver keeps up. Evaluation is the single combinational pass
// over the bank comparators between the state and result registers.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled receiver holds its result and stops further events only once
// the register is full. Registers are written on the cfg channel, which is
// always ready; writes are expected while no event is in flight.
// Reset clears all gesture state, the latch and the tap timer and loads the
// register reset values; no clearing pass follows.
// ----------------------------------------------------------------------------
module touch_sweep_gesture_detector_core
	import tsgd_pkg::*;
#(
	parameter int STATIC_BANK_COUNT  = 4,
	parameter int DYNAMIC_BANK_COUNT = 1,
	parameter int COORD_BITS         = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // coord_value[11:0], zero padding
	input  logic [2:0]  s_tuser,   // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // press_count[2:0], static_fired[6:3],
	                               // dynamic_fired[7], double_tap_fired[8], padding
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LATCH_BITS = (COORD_BITS < IN_COORD_BITS) ? COORD_BITS : IN_COORD_BITS;

	logic [8:0]  enable_mask_q;
	logic [11:0] button_limit_q;
	logic [11:0] status_bar_q;
	logic [15:0] tap_window_q;

	logic [LATCH_BITS-1:0] latched_x_q;
	logic [LATCH_BITS-1:0] latched_y_q;
	logic                  x_seen_q;
	logic                  y_seen_q;
	logic                  screen_off_q;
	stage_t                stage_q;

	logic                  m_valid_q;
	logic [15:0]           m_data_q;

	logic                  accept;
	cmd_t                  cmd;
	logic                  active;
	logic [LATCH_BITS-1:0] coord;
	logic [11:0]           latched_y_ext;

	logic [LATCH_BITS-1:0] nx;
	logic [LATCH_BITS-1:0] ny;
	logic                  nxs;
	logic                  nys;
	logic                  nscr;
	logic                  do_detect;
	stage_t                stage_d;

	stage_t                    det_stage;
	logic [PRESS_SUM_BITS-1:0] det_presses;
	logic [TABLE_SIZE-1:0]     det_static;
	logic                      det_dynamic;

	tap_ctrl_t             tap_ctrl;
	logic                  tap_armed;
	logic                  tap_fire;
	logic [PRESS_BITS-1:0] press_out;
	logic [15:0]           result;

	assign accept        = s_tvalid && s_tready;
	assign s_tready      = !m_valid_q || m_tready;
	assign cmd           = cmd_t'(s_tuser);
	assign active        = enable_mask_q != 9'd0;
	assign coord         = s_tdata[LATCH_BITS-1:0];
	assign latched_y_ext = {{(IN_COORD_BITS-LATCH_BITS){1'b0}}, latched_y_q};
	assign cfg_ready     = 1'b1;

	always_comb begin
		nx        = latched_x_q;
		ny        = latched_y_q;
		nxs       = x_seen_q;
		nys       = y_seen_q;
		nscr      = screen_off_q;
		do_detect = 1'b0;
		stage_d   = stage_q;
		case (cmd)
			CMD_X: begin
				if (active) begin
					nx  = coord;
					nxs = 1'b1;
				end
			end
			CMD_Y: begin
				if (active) begin
					ny  = coord;
					nys = 1'b1;
				end
			end
			CMD_SLOT: begin
				if (active) begin
					stage_d = clear_stages(stage_q);
				end
			end
			CMD_LIFT: begin
				if (active && latched_y_ext < button_limit_q) begin
					stage_d = clear_stages(stage_q);
				end
			end
			CMD_SCREEN_ON: begin
				nscr = 1'b0;
			end
			CMD_SCREEN_OFF: begin
				nscr = 1'b1;
			end
			default: begin
			end
		endcase
		if ((cmd == CMD_X || cmd == CMD_Y) && active && nxs && nys) begin
			nxs = 1'b0;
			nys = 1'b0;
			if (!screen_off_q) begin
				do_detect = 1'b1;
				stage_d   = det_stage;
			end
		end
	end

	tsgd_detect #(
		.STATIC_BANK_COUNT (STATIC_BANK_COUNT),
		.DYNAMIC_BANK_COUNT(DYNAMIC_BANK_COUNT),
		.LATCH_BITS        (LATCH_BITS)
	) u_detect (
		.x            (nx),
		.y            (ny),
		.enable_mask  (enable_mask_q),
		.stage_in     (stage_q),
		.stage_out    (det_stage),
		.presses      (det_presses),
		.static_fired (det_static),
		.dynamic_fired(det_dynamic)
	);

	assign tap_ctrl.tap  = accept && cmd == CMD_LIFT && active && enable_mask_q[TAP_EN_BIT]
		&& latched_y_ext <= status_bar_q && !screen_off_q;
	assign tap_ctrl.tick = accept && cmd == CMD_TICK;

	tsgd_tap u_tap (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (tap_ctrl),
		.window(tap_window_q),
		.armed (tap_armed),
		.fire  (tap_fire)
	);

	always_comb begin
		press_out = {{(PRESS_BITS-1){1'b0}}, tap_fire};
		if (do_detect) begin
			press_out = det_presses[PRESS_SUM_BITS-1] ? {PRESS_BITS{1'b1}}
				: det_presses[PRESS_BITS-1:0];
		end
		result = {7'd0, tap_fire, do_detect && det_dynamic,
			do_detect ? det_static : {TABLE_SIZE{1'b0}}, press_out};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q  <= '0;
			button_limit_q <= 12'd1900;
			status_bar_q   <= 12'd80;
			tap_window_q   <= 16'd800;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENABLE_MASK:  enable_mask_q  <= cfg_data[8:0];
				CFG_BUTTON_LIMIT: button_limit_q <= cfg_data[11:0];
				CFG_STATUS_BAR:   status_bar_q   <= cfg_data[11:0];
				CFG_TAP_WINDOW:   tap_window_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_x_q  <= '0;
			latched_y_q  <= '0;
			x_seen_q     <= 1'b0;
			y_seen_q     <= 1'b0;
			screen_off_q <= 1'b0;
			stage_q      <= '0;
		end else if (accept) begin
			latched_x_q  <= nx;
			latched_y_q  <= ny;
			x_seen_q     <= nxs;
			y_seen_q     <= nys;
			screen_off_q <= nscr;
			stage_q      <= stage_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_tap_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[8] |-> m_data_q[2:0] == 3'd1 && m_data_q[7:3] == 5'd0)
		else $error("double tap result carries other firings");

	a_fired_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[8:3] != 6'd0 |-> m_data_q[2:0] != 3'd0)
		else $error("firing reported without a press");

	a_bank_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q[6:3] >> STATIC_BANK_COUNT) == 4'd0)
		else $error("firing reported for an absent static bank");

	a_slot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_SLOT && active |=>
			stage_q.s1 == '0 && stage_q.s2 == '0 && !stage_q.d1 && !stage_q.d2)
		else $error("slot change left gesture stages set");

	a_disarm_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(tap_armed) |-> $past(tap_ctrl.tap || tap_ctrl.tick))
		else $error("double tap disarmed without a lift or tick");

endmodule
